// ----- src/encvel_pkg.sv -----
package encvel_pkg;

    localparam int DATA_W    = 32;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 58;
    localparam int CFG_IDX_W = 4;

    localparam logic [DATA_W-1:0] TPR_RESET = 32'd85445;
    localparam logic [DATA_W-1:0] RPT_RESET = 32'd3294199;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPR = 4'd0,
        CFG_RPT = 4'd1,
        CFG_B0  = 4'd2,
        CFG_B1  = 4'd3,
        CFG_B2  = 4'd4,
        CFG_B3  = 4'd5,
        CFG_A1  = 4'd6,
        CFG_A2  = 4'd7
    } t_cfg_idx;

    // issue order of the shared multiplier; quant product lands before B1 needs it
    typedef enum logic [2:0] {
        OP_TICKS = 3'd0,
        OP_QUANT = 3'd1,
        OP_B0    = 3'd2,
        OP_A1    = 3'd3,
        OP_A2    = 3'd4,
        OP_B1    = 3'd5,
        OP_B2    = 3'd6,
        OP_B3    = 3'd7
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mul_op mul_op;
        logic    finish;
    } t_dp_cmd;

endpackage

// ----- src/encvel_dp.sv -----
module encvel_dp
    import encvel_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_angle,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output logic signed [DATA_W-1:0] o_quantized_angle,
    output logic signed [DATA_W-1:0] o_velocity,
    output logic                     o_saturated
);

    function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [DATA_W:0] res;
        if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
            res = {1'b0, v[DATA_W-1:0]};
        end else if (v[ACC_W-1]) begin
            res = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic        [DATA_W-1:0] r_tpr;
    logic        [DATA_W-1:0] r_rpt;
    logic signed [DATA_W-1:0] r_b0, r_b1, r_b2, r_b3, r_a1, r_a2;
    logic signed [DATA_W-1:0] r_xh [4];
    logic signed [DATA_W-1:0] r_y1, r_y2;

    logic signed [DATA_W-1:0] r_angle;
    logic                     r_allzero;
    logic signed [PROD_W-1:0] r_prod;
    t_mul_op                  r_prod_op;
    logic                     r_prod_vld;
    logic signed [DATA_W-1:0] r_quant;
    logic                     r_quant_sat;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [DATA_W-1:0] r_out_q;
    logic signed [DATA_W-1:0] r_out_vel;
    logic                     r_out_sat;

    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [MUL_W-1:0]  w_ticks;
    logic signed [DATA_W-1:0] w_x1, w_x2, w_x3;
    logic signed [ACC_W-1:0]  w_term;
    logic                     w_term_en;
    logic [DATA_W:0]          w_q_sat;
    logic [DATA_W:0]          w_v_sat;

    assign w_ticks = MUL_W'(r_prod >>> 40);
    assign w_x1    = r_allzero ? r_quant : r_xh[0];
    assign w_x2    = r_allzero ? r_quant : r_xh[1];
    assign w_x3    = r_allzero ? r_quant : r_xh[2];

    always_comb begin
        case (i_cmd.mul_op)
            OP_TICKS: begin
                w_mul_a = {r_angle[DATA_W-1], r_angle};
                w_mul_b = {1'b0, r_tpr};
            end
            OP_QUANT: begin
                w_mul_a = w_ticks;
                w_mul_b = {1'b0, r_rpt};
            end
            OP_B0: begin
                w_mul_a = {r_angle[DATA_W-1], r_angle};
                w_mul_b = {r_b0[DATA_W-1], r_b0};
            end
            OP_A1: begin
                w_mul_a = {r_y1[DATA_W-1], r_y1};
                w_mul_b = {r_a1[DATA_W-1], r_a1};
            end
            OP_A2: begin
                w_mul_a = {r_y2[DATA_W-1], r_y2};
                w_mul_b = {r_a2[DATA_W-1], r_a2};
            end
            OP_B1: begin
                w_mul_a = {w_x1[DATA_W-1], w_x1};
                w_mul_b = {r_b1[DATA_W-1], r_b1};
            end
            OP_B2: begin
                w_mul_a = {w_x2[DATA_W-1], w_x2};
                w_mul_b = {r_b2[DATA_W-1], r_b2};
            end
            OP_B3: begin
                w_mul_a = {w_x3[DATA_W-1], w_x3};
                w_mul_b = {r_b3[DATA_W-1], r_b3};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // feedforward terms drop 16 bits, feedback terms drop 8 and subtract
    always_comb begin
        case (r_prod_op)
            OP_B0, OP_B1, OP_B2, OP_B3: begin
                w_term    = ACC_W'(r_prod >>> 16);
                w_term_en = r_prod_vld;
            end
            OP_A1, OP_A2: begin
                w_term    = -ACC_W'(r_prod >>> 8);
                w_term_en = r_prod_vld;
            end
            default: begin
                w_term    = '0;
                w_term_en = 1'b0;
            end
        endcase
    end

    assign w_q_sat = sat32(ACC_W'(r_prod >>> 8));
    assign w_v_sat = sat32(ACC_W'(r_acc >>> 8));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpr      <= TPR_RESET;
            r_rpt      <= RPT_RESET;
            r_b0       <= '0;
            r_b1       <= '0;
            r_b2       <= '0;
            r_b3       <= '0;
            r_a1       <= '0;
            r_a2       <= '0;
            r_xh[0]    <= '0;
            r_xh[1]    <= '0;
            r_xh[2]    <= '0;
            r_xh[3]    <= '0;
            r_y1       <= '0;
            r_y2       <= '0;
            r_prod_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TPR: r_tpr <= i_cfg_data;
                    CFG_RPT: r_rpt <= i_cfg_data;
                    CFG_B0:  r_b0  <= i_cfg_data;
                    CFG_B1:  r_b1  <= i_cfg_data;
                    CFG_B2:  r_b2  <= i_cfg_data;
                    CFG_B3:  r_b3  <= i_cfg_data;
                    CFG_A1:  r_a1  <= i_cfg_data;
                    CFG_A2:  r_a2  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.finish) begin
                r_xh[0] <= r_angle;
                r_xh[1] <= w_x1;
                r_xh[2] <= w_x2;
                r_xh[3] <= w_x3;
                r_y1    <= w_v_sat[DATA_W-1:0];
                r_y2    <= r_y1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_angle   <= i_angle;
            r_allzero <= ~|{r_xh[0], r_xh[1], r_xh[2], r_xh[3]};
            r_acc     <= '0;
        end else if (w_term_en) begin
            r_acc <= r_acc + w_term;
        end
        if (i_cmd.mul_en) begin
            r_prod    <= w_prod;
            r_prod_op <= i_cmd.mul_op;
        end
        if (r_prod_vld && r_prod_op == OP_QUANT) begin
            r_quant     <= w_q_sat[DATA_W-1:0];
            r_quant_sat <= w_q_sat[DATA_W];
        end
        if (i_cmd.finish) begin
            r_out_q   <= r_quant;
            r_out_vel <= w_v_sat[DATA_W-1:0];
            r_out_sat <= r_quant_sat | w_v_sat[DATA_W];
        end
    end

    assign o_quantized_angle = r_out_q;
    assign o_velocity        = r_out_vel;
    assign o_saturated       = r_out_sat;

endmodule

// ----- src/encvel_ctrl.sv -----
module encvel_ctrl
    import encvel_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state     r_state;
    logic [2:0] r_step;
    logic       r_out_vld;
    logic       w_out_free;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_en = (r_state == S_RUN);
        o_cmd.mul_op = t_mul_op'(r_step);
        o_cmd.finish = (r_state == S_FIN) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 3'd1;
                    if (&r_step) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_RUN && r_step == 3'd0))
        else $error("accepted word did not start the product sequence");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the finish state");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free) |=> (r_out_vld && r_state == S_IDLE))
        else $error("finish did not hand the word to the output register");

endmodule

// ----- src/encoder_quantize_iir_velocity_unit.sv -----
// Quantizes a Q8.24 joint angle to whole encoder counts and estimates velocity
// with a 4-input, 2-feedback-tap IIR filter on the raw angle; both results
// saturate to 32 bits and o_saturated flags a clip. One word is processed at a
// time (o_in_stall is high outside the idle state): one shared 33x33 multiplier
// computes the eight products of each sample one per cycle, followed by a drain
// state for the accumulator, a finish state that loads the output register and an
// idle state in which the next word is taken. A result waiting in the output
// register does not block computing the next word, only its finish.
module encoder_quantize_iir_velocity_unit
    import encvel_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_angle,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_quantized_angle,
    output logic signed [DATA_W-1:0] o_velocity,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    t_dp_cmd w_cmd;

    encvel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    encvel_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_angle           (i_angle),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_quantized_angle (o_quantized_angle),
        .o_velocity        (o_velocity),
        .o_saturated       (o_saturated)
    );

endmodule
